// ===== rtl/slpg_pkg.sv =====
// Shared types, register map and constants for the status LED pattern generator.
// Used by every file under rtl; depends on nothing.
package slpg_pkg;

	localparam int unsigned TIME_W     = 32;
	localparam int unsigned PER_W      = 16;
	localparam int unsigned SLOT_W     = 12;
	localparam int unsigned BRIGHT_W   = 7;
	localparam int unsigned CHAN_W     = 8;
	localparam int unsigned ADDR_W     = 5;
	localparam int unsigned DATA_W     = 32;
	localparam int unsigned THR_W      = 15;
	localparam int unsigned PROD_W     = 15;
	localparam int unsigned STEP_BITS  = 4;
	localparam int unsigned DIV_STAGES = TIME_W / STEP_BITS;

	localparam logic [2:0] MODE_DISARMED = 3'd0;
	localparam logic [2:0] MODE_ARMED    = 3'd1;
	localparam logic [2:0] MODE_FAILSAFE = 3'd2;
	localparam logic [2:0] MODE_ESC_CAL  = 3'd3;
	localparam logic [2:0] MODE_DEPLOY   = 3'd4;

	localparam logic [2:0] REG_FAILSAFE_PERIOD = 3'd0;
	localparam logic [2:0] REG_DISARMED_PERIOD = 3'd1;
	localparam logic [2:0] REG_CAL_PERIOD      = 3'd2;
	localparam logic [2:0] REG_DEPLOY_PERIOD   = 3'd3;
	localparam logic [2:0] REG_SLOT_LENGTH     = 3'd4;
	localparam logic [2:0] REG_BRIGHTNESS      = 3'd5;

	localparam logic [PER_W-1:0]    RST_FAILSAFE_PERIOD = 16'd250;
	localparam logic [PER_W-1:0]    RST_DISARMED_PERIOD = 16'd2000;
	localparam logic [PER_W-1:0]    RST_CAL_PERIOD      = 16'd1000;
	localparam logic [PER_W-1:0]    RST_DEPLOY_PERIOD   = 16'd2000;
	localparam logic [SLOT_W-1:0]   RST_SLOT_LENGTH     = 12'd100;
	localparam logic [BRIGHT_W-1:0] RST_BRIGHTNESS      = 7'd100;

	localparam logic [CHAN_W-1:0] CHAN_FULL = 8'd255;

	// x / 100 == (x * 5243) >> 19 for x below 2^15
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int unsigned RECIP_SHIFT = 19;
	localparam int unsigned MUL_W       = PROD_W + 13;

	typedef struct packed {
		logic [2:0]        mode;
		logic              calibrated;
		logic [TIME_W-1:0] time_ms;
	} in_t;

	typedef struct packed {
		logic              led_on;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} out_t;

	typedef struct packed {
		logic [2:0]        mode;
		logic              calibrated;
		logic [PER_W-1:0]  period;
		logic [TIME_W-1:0] time_ms;
		logic [PER_W-1:0]  rem;
	} div_t;

	// one restoring remainder step: shift in one time bit, subtract period if it fits
	function automatic logic [PER_W-1:0] rem_step(input logic [PER_W-1:0] rem,
		input logic din, input logic [PER_W-1:0] per);
		logic [PER_W:0] t;
		logic [PER_W:0] d;
		t = {rem, din};
		d = t - {1'b0, per};
		if (t >= {1'b0, per}) begin
			return d[PER_W-1:0];
		end
		return t[PER_W-1:0];
	endfunction

endpackage

// ===== rtl/status_led_pattern_generator.sv =====
// Status LED pattern generator top level: APB register file, remainder pipeline, color output.
// Depends on slpg_pkg.
//
// Usage: an input beat (mode, calibrated, time_ms) on in_valid/in_ready yields exactly one
// output beat (led_on, red, green, blue) on out_valid/out_ready, in input order.
// One beat is accepted every cycle while no back-pressure from out_ready stalls the pipeline.
// The phase time_ms mod period is a 32-step restoring remainder, four steps in each of
// eight pipeline stages; the ninth stage picks the blink slot and the color and is the
// output register.
// Periods, slot length and brightness sit in APB registers at byte addresses 0, 4, 8, 12,
// 16, 20; a zero period or slot length acts as one. Write them only while the pipeline is
// empty; after a write, thresholds follow next cycle, color levels via product and level registers.
// Reset clears all stage valid bits and loads the register defaults.
// When out_ready is low the output beat holds and each full stage holds while the stage
// after it holds; in_ready drops only when every stage is occupied.
// pready is always high; reads return the stored register value.
module status_led_pattern_generator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  slpg_pkg::in_t                in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output slpg_pkg::out_t               out_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [slpg_pkg::ADDR_W-1:0]  paddr,
	input  logic [slpg_pkg::DATA_W-1:0]  pwdata,
	output logic [slpg_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);

	localparam int unsigned NS = slpg_pkg::DIV_STAGES;

	logic [slpg_pkg::PER_W-1:0]    fs_per_q, dis_per_q, cal_per_q, dep_per_q;
	logic [slpg_pkg::SLOT_W-1:0]   slot_q;
	logic [slpg_pkg::BRIGHT_W-1:0] bright_q;

	logic [slpg_pkg::THR_W-1:0] thr1_q, thr2_q, thr3_q, thr4_q, thr5_q;
	logic [slpg_pkg::PROD_W-1:0] prod_full_q, prod_amber_q;
	logic [slpg_pkg::CHAN_W-1:0] lvl_full_q, lvl_amber_q;

	logic [2:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[slpg_pkg::ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_per_q  <= slpg_pkg::RST_FAILSAFE_PERIOD;
			dis_per_q <= slpg_pkg::RST_DISARMED_PERIOD;
			cal_per_q <= slpg_pkg::RST_CAL_PERIOD;
			dep_per_q <= slpg_pkg::RST_DEPLOY_PERIOD;
			slot_q    <= slpg_pkg::RST_SLOT_LENGTH;
			bright_q  <= slpg_pkg::RST_BRIGHTNESS;
		end else if (wr_en) begin
			case (reg_idx)
				slpg_pkg::REG_FAILSAFE_PERIOD: fs_per_q  <= pwdata[slpg_pkg::PER_W-1:0];
				slpg_pkg::REG_DISARMED_PERIOD: dis_per_q <= pwdata[slpg_pkg::PER_W-1:0];
				slpg_pkg::REG_CAL_PERIOD:      cal_per_q <= pwdata[slpg_pkg::PER_W-1:0];
				slpg_pkg::REG_DEPLOY_PERIOD:   dep_per_q <= pwdata[slpg_pkg::PER_W-1:0];
				slpg_pkg::REG_SLOT_LENGTH:     slot_q    <= pwdata[slpg_pkg::SLOT_W-1:0];
				slpg_pkg::REG_BRIGHTNESS:      bright_q  <= pwdata[slpg_pkg::BRIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			slpg_pkg::REG_FAILSAFE_PERIOD: prdata[slpg_pkg::PER_W-1:0]    = fs_per_q;
			slpg_pkg::REG_DISARMED_PERIOD: prdata[slpg_pkg::PER_W-1:0]    = dis_per_q;
			slpg_pkg::REG_CAL_PERIOD:      prdata[slpg_pkg::PER_W-1:0]    = cal_per_q;
			slpg_pkg::REG_DEPLOY_PERIOD:   prdata[slpg_pkg::PER_W-1:0]    = dep_per_q;
			slpg_pkg::REG_SLOT_LENGTH:     prdata[slpg_pkg::SLOT_W-1:0]   = slot_q;
			slpg_pkg::REG_BRIGHTNESS:      prdata[slpg_pkg::BRIGHT_W-1:0] = bright_q;
			default: ;
		endcase
	end

	// slot thresholds and scaled color levels, derived from the registers
	logic [slpg_pkg::THR_W-1:0] slot_nz;
	logic [slpg_pkg::MUL_W-1:0] mul_full, mul_amber;
	logic [slpg_pkg::MUL_W-slpg_pkg::RECIP_SHIFT-1:0] quo_full, quo_amber;

	assign slot_nz   = (slot_q == '0) ? slpg_pkg::THR_W'(1) : slpg_pkg::THR_W'(slot_q);
	assign mul_full  = slpg_pkg::MUL_W'(prod_full_q) * slpg_pkg::MUL_W'(slpg_pkg::RECIP_100);
	assign mul_amber = slpg_pkg::MUL_W'(prod_amber_q) * slpg_pkg::MUL_W'(slpg_pkg::RECIP_100);
	assign quo_full  = mul_full[slpg_pkg::MUL_W-1:slpg_pkg::RECIP_SHIFT];
	assign quo_amber = mul_amber[slpg_pkg::MUL_W-1:slpg_pkg::RECIP_SHIFT];

	always_ff @(posedge clk) begin
		thr1_q       <= slot_nz;
		thr2_q       <= slot_nz << 1;
		thr3_q       <= slot_nz + (slot_nz << 1);
		thr4_q       <= slot_nz << 2;
		thr5_q       <= slot_nz + (slot_nz << 2);
		prod_full_q  <= (slpg_pkg::PROD_W'(bright_q) << 8) - slpg_pkg::PROD_W'(bright_q);
		prod_amber_q <= (slpg_pkg::PROD_W'(bright_q) << 7) + (slpg_pkg::PROD_W'(bright_q) << 5);
		lvl_full_q   <= (quo_full > slpg_pkg::CHAN_FULL) ? slpg_pkg::CHAN_FULL
			: quo_full[slpg_pkg::CHAN_W-1:0];
		lvl_amber_q  <= (quo_amber > slpg_pkg::CHAN_FULL) ? slpg_pkg::CHAN_FULL
			: quo_amber[slpg_pkg::CHAN_W-1:0];
	end

	// remainder pipeline
	logic                       adv [1:NS+1];
	logic                       vld_s [1:NS];
	slpg_pkg::div_t             div_s [1:NS];
	slpg_pkg::div_t             first;
	logic [slpg_pkg::PER_W-1:0] per_sel;
	logic                       vld_s9;

	always_comb begin
		case (in_data.mode)
			slpg_pkg::MODE_FAILSAFE: per_sel = fs_per_q;
			slpg_pkg::MODE_ESC_CAL:  per_sel = cal_per_q;
			slpg_pkg::MODE_DEPLOY:   per_sel = dep_per_q;
			default:                 per_sel = dis_per_q;
		endcase
		first.mode       = in_data.mode;
		first.calibrated = in_data.calibrated;
		first.period     = (per_sel == '0) ? slpg_pkg::PER_W'(1) : per_sel;
		first.time_ms    = in_data.time_ms;
		first.rem        = '0;
	end

	assign adv[NS+1] = !vld_s9 || out_ready;
	assign in_ready  = adv[1];

	for (genvar g = 0; g < NS; g++) begin : g_div
		localparam int BASE = slpg_pkg::TIME_W - 1 - g * slpg_pkg::STEP_BITS;
		slpg_pkg::div_t src, nxt;
		logic           src_vld;

		if (g == 0) begin : g_head
			assign src     = first;
			assign src_vld = in_valid;
		end else begin : g_body
			assign src     = div_s[g];
			assign src_vld = vld_s[g];
		end

		assign adv[g+1] = !vld_s[g+1] || adv[g+2];

		always_comb begin
			nxt = src;
			for (int j = 0; j < slpg_pkg::STEP_BITS; j++) begin
				nxt.rem = slpg_pkg::rem_step(nxt.rem, src.time_ms[BASE-j], src.period);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (adv[g+1]) begin
				vld_s[g+1] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[g+1] && src_vld) begin
				div_s[g+1] <= nxt;
			end
		end
	end

	// pattern decode and color
	slpg_pkg::div_t             last;
	logic [slpg_pkg::PER_W-1:0] ph;
	logic                       in_s1, in_s3, in_s5, below4, half_lit, dbl, tpl, lit;
	slpg_pkg::out_t             res;

	assign last     = div_s[NS];
	assign ph       = last.rem;
	assign in_s1    = ph < slpg_pkg::PER_W'(thr1_q);
	assign in_s3    = (ph >= slpg_pkg::PER_W'(thr2_q)) && (ph < slpg_pkg::PER_W'(thr3_q));
	assign in_s5    = (ph >= slpg_pkg::PER_W'(thr4_q)) && (ph < slpg_pkg::PER_W'(thr5_q));
	assign below4   = ph < slpg_pkg::PER_W'(thr4_q);
	assign half_lit = ph < (last.period >> 1);
	assign dbl      = in_s1 || in_s3;
	assign tpl      = dbl || in_s5;

	always_comb begin
		res = '0;
		case (last.mode)
			slpg_pkg::MODE_ARMED: begin
				lit       = 1'b1;
				res.green = lvl_full_q;
			end
			slpg_pkg::MODE_FAILSAFE: begin
				lit     = half_lit;
				res.red = lvl_full_q;
			end
			slpg_pkg::MODE_ESC_CAL: begin
				lit      = dbl;
				res.blue = lvl_full_q;
			end
			slpg_pkg::MODE_DEPLOY: begin
				lit       = tpl;
				res.green = lvl_full_q;
				res.blue  = lvl_full_q;
			end
			default: begin
				lit       = (!last.calibrated && below4) ? dbl : half_lit;
				res.red   = lvl_full_q;
				res.green = lvl_amber_q;
			end
		endcase
		if (!lit) begin
			res = '0;
		end
		res.led_on = lit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (adv[NS+1]) begin
			vld_s9 <= vld_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NS+1] && vld_s[NS]) begin
			out_data <= res;
		end
	end

	assign out_valid = vld_s9;

endmodule

// ===== rtl/slpg_checker.sv =====
// Port-level checker for the status LED pattern generator, with its bind statement.
// Depends on slpg_pkg and on status_led_pattern_generator.
module slpg_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input slpg_pkg::out_t               out_data
);

	// a draining output lets every stage advance
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("in_ready low while out_ready high");

	// a dark beat carries no color
	a_dark_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.led_on) |->
		(out_data.red == '0 && out_data.green == '0 && out_data.blue == '0))
		else $error("color on an unlit beat");

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("output beat changed under stall");

	// no output beat is valid when reset is released
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("output beat right after reset");

endmodule

bind status_led_pattern_generator slpg_checker u_slpg_checker (.*);

// ===== sim/tb_status_led_pattern_generator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for status_led_pattern_generator: directed and random beats under
// random register settings and back-pressure, each result checked against an in-bench predictor.
// Depends on slpg_pkg (rtl/slpg_pkg.sv) and rtl/status_led_pattern_generator.sv.
module tb_status_led_pattern_generator;

	localparam int unsigned PIPE_LATENCY = 9;
	localparam int unsigned DRAIN_CYCLES = 2 * PIPE_LATENCY;
	localparam int unsigned LONG_STALL   = 80;
	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned PERCENT      = 100;
	localparam int unsigned DOUBLE_SLOTS = 4;
	localparam int unsigned TRIPLE_SLOTS = 6;
	localparam logic [2:0]  REG_SPARE_A  = 3'd6;
	localparam logic [2:0]  REG_SPARE_B  = 3'd7;
	localparam logic [slpg_pkg::CHAN_W-1:0] AMBER_GREEN = 8'd160;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	slpg_pkg::in_t               in_data;
	logic                        out_valid;
	logic                        out_ready;
	slpg_pkg::out_t              out_data;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [slpg_pkg::ADDR_W-1:0] paddr;
	logic [slpg_pkg::DATA_W-1:0] pwdata;
	logic [slpg_pkg::DATA_W-1:0] prdata;
	logic                        pready;

	logic [slpg_pkg::PER_W-1:0]    failsafe_per;
	logic [slpg_pkg::PER_W-1:0]    disarmed_per;
	logic [slpg_pkg::PER_W-1:0]    cal_per;
	logic [slpg_pkg::PER_W-1:0]    deploy_per;
	logic [slpg_pkg::SLOT_W-1:0]   slot_len;
	logic [slpg_pkg::BRIGHT_W-1:0] bright_pct;

	slpg_pkg::out_t expected_leds[$];
	int unsigned    error_count = 0;
	int unsigned    idle_cycles = 0;
	bit             long_stall_req = 1'b0;

	status_led_pattern_generator dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned at_least_one(int unsigned v);
		return (v == 0) ? 1 : v;
	endfunction

	function automatic logic [slpg_pkg::CHAN_W-1:0] scale_channel(
		logic [slpg_pkg::CHAN_W-1:0] level);
		int unsigned v;
		v = 32'(level);
		v = v * 32'(bright_pct) / PERCENT;
		return (v > slpg_pkg::CHAN_FULL) ? slpg_pkg::CHAN_FULL : v[slpg_pkg::CHAN_W-1:0];
	endfunction

	function automatic slpg_pkg::out_t predict_led(slpg_pkg::in_t req);
		int unsigned slot;
		int unsigned per;
		int unsigned phase;
		int unsigned idx;
		logic lit;
		logic [slpg_pkg::CHAN_W-1:0] r;
		logic [slpg_pkg::CHAN_W-1:0] g;
		logic [slpg_pkg::CHAN_W-1:0] b;
		slpg_pkg::out_t res;
		slot = at_least_one(32'(slot_len));
		case (req.mode)
		slpg_pkg::MODE_ARMED: begin
			lit = 1'b1;
			r = '0;
			g = slpg_pkg::CHAN_FULL;
			b = '0;
		end
		slpg_pkg::MODE_FAILSAFE: begin
			per = at_least_one(32'(failsafe_per));
			lit = (req.time_ms % per) < (per / 2);
			r = slpg_pkg::CHAN_FULL;
			g = '0;
			b = '0;
		end
		slpg_pkg::MODE_ESC_CAL: begin
			phase = req.time_ms % at_least_one(32'(cal_per));
			idx = phase / slot;
			lit = (phase < slot * DOUBLE_SLOTS) && (idx == 0 || idx == 2);
			r = '0;
			g = '0;
			b = slpg_pkg::CHAN_FULL;
		end
		slpg_pkg::MODE_DEPLOY: begin
			phase = req.time_ms % at_least_one(32'(deploy_per));
			idx = phase / slot;
			lit = (phase < slot * TRIPLE_SLOTS) && (idx == 0 || idx == 2 || idx == 4);
			r = '0;
			g = slpg_pkg::CHAN_FULL;
			b = slpg_pkg::CHAN_FULL;
		end
		default: begin
			per = at_least_one(32'(disarmed_per));
			phase = req.time_ms % per;
			idx = phase / slot;
			if (!req.calibrated && phase < slot * DOUBLE_SLOTS) begin
				lit = (idx == 0 || idx == 2);
			end else begin
				lit = phase < (per / 2);
			end
			r = slpg_pkg::CHAN_FULL;
			g = AMBER_GREEN;
			b = '0;
		end
		endcase
		res.led_on = lit;
		res.red    = lit ? scale_channel(r) : '0;
		res.green  = lit ? scale_channel(g) : '0;
		res.blue   = lit ? scale_channel(b) : '0;
		return res;
	endfunction

	function automatic logic [slpg_pkg::DATA_W-1:0] stored_value(logic [2:0] idx);
		case (idx)
		slpg_pkg::REG_FAILSAFE_PERIOD: return slpg_pkg::DATA_W'(failsafe_per);
		slpg_pkg::REG_DISARMED_PERIOD: return slpg_pkg::DATA_W'(disarmed_per);
		slpg_pkg::REG_CAL_PERIOD:      return slpg_pkg::DATA_W'(cal_per);
		slpg_pkg::REG_DEPLOY_PERIOD:   return slpg_pkg::DATA_W'(deploy_per);
		slpg_pkg::REG_SLOT_LENGTH:     return slpg_pkg::DATA_W'(slot_len);
		slpg_pkg::REG_BRIGHTNESS:      return slpg_pkg::DATA_W'(bright_pct);
		default:                       return '0;
		endcase
	endfunction

	function automatic slpg_pkg::in_t make_request(logic [2:0] mode, logic cal,
		logic [slpg_pkg::TIME_W-1:0] t);
		slpg_pkg::in_t req;
		req.mode       = mode;
		req.calibrated = cal;
		req.time_ms    = t;
		return req;
	endfunction

	// half of the beats land near a period start, where the slot patterns live
	function automatic slpg_pkg::in_t random_request();
		int unsigned per;
		slpg_pkg::in_t req;
		req.mode       = 3'($urandom_range(0, 7));
		req.calibrated = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 1)) begin
			req.time_ms = $urandom;
		end else begin
			case (req.mode)
			slpg_pkg::MODE_FAILSAFE: per = 32'(failsafe_per);
			slpg_pkg::MODE_ESC_CAL:  per = 32'(cal_per);
			slpg_pkg::MODE_DEPLOY:   per = 32'(deploy_per);
			default:                 per = 32'(disarmed_per);
			endcase
			req.time_ms = at_least_one(per) * $urandom_range(0, 65535)
				+ $urandom_range(0, 8 * (slot_len + 1));
		end
		return req;
	endfunction

	function automatic logic [slpg_pkg::PER_W-1:0] pick_period();
		case ($urandom_range(0, 5))
		0:       return '0;
		1:       return slpg_pkg::PER_W'(1);
		2:       return '1;
		3:       return slpg_pkg::PER_W'($urandom_range(2, 64));
		4:       return slpg_pkg::PER_W'($urandom_range(100, 5000));
		default: return slpg_pkg::PER_W'($urandom);
		endcase
	endfunction

	function automatic void compare_field(string name, logic [slpg_pkg::CHAN_W-1:0] want,
		logic [slpg_pkg::CHAN_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endfunction

	task automatic apb_transfer(input logic is_write, input logic [2:0] idx,
		input logic [slpg_pkg::DATA_W-1:0] wdata, output logic [slpg_pkg::DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_readback(input logic [2:0] idx);
		logic [slpg_pkg::DATA_W-1:0] rdata;
		apb_transfer(1'b0, idx, '0, rdata);
		if (rdata !== stored_value(idx)) begin
			$error("register %0d: expected %0h, got %0h", idx, stored_value(idx), rdata);
			error_count++;
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [slpg_pkg::DATA_W-1:0] value);
		logic [slpg_pkg::DATA_W-1:0] rdata;
		apb_transfer(1'b1, idx, value, rdata);
		case (idx)
		slpg_pkg::REG_FAILSAFE_PERIOD: failsafe_per = value[slpg_pkg::PER_W-1:0];
		slpg_pkg::REG_DISARMED_PERIOD: disarmed_per = value[slpg_pkg::PER_W-1:0];
		slpg_pkg::REG_CAL_PERIOD:      cal_per      = value[slpg_pkg::PER_W-1:0];
		slpg_pkg::REG_DEPLOY_PERIOD:   deploy_per   = value[slpg_pkg::PER_W-1:0];
		slpg_pkg::REG_SLOT_LENGTH:     slot_len     = value[slpg_pkg::SLOT_W-1:0];
		slpg_pkg::REG_BRIGHTNESS:      bright_pct   = value[slpg_pkg::BRIGHT_W-1:0];
		default: ;
		endcase
		if (idx <= slpg_pkg::REG_BRIGHTNESS) begin
			check_readback(idx);
		end
	endtask

	task automatic send_beat(input slpg_pkg::in_t req);
		in_data  <= req;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_leds.push_back(predict_led(req));
	endtask

	task automatic pause_sender(input int unsigned cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (expected_leds.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_traffic(input int unsigned count);
		int unsigned burst;
		while (count > 0) begin
			burst = $urandom_range(1, 32);
			if (burst > count) begin
				burst = count;
			end
			repeat (burst) send_beat(random_request());
			count -= burst;
			pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
		end
	endtask

	task automatic apply_settings(input logic [slpg_pkg::PER_W-1:0] fs, dis, cal, dep,
		input logic [slpg_pkg::SLOT_W-1:0] slot, input logic [slpg_pkg::BRIGHT_W-1:0] pct);
		logic [slpg_pkg::DATA_W-1:0] noise;
		wait_results_drained();
		noise = $urandom;
		write_reg(slpg_pkg::REG_FAILSAFE_PERIOD, {noise[slpg_pkg::DATA_W-1:slpg_pkg::PER_W], fs});
		noise = $urandom;
		write_reg(slpg_pkg::REG_DISARMED_PERIOD,
			{noise[slpg_pkg::DATA_W-1:slpg_pkg::PER_W], dis});
		noise = $urandom;
		write_reg(slpg_pkg::REG_CAL_PERIOD, {noise[slpg_pkg::DATA_W-1:slpg_pkg::PER_W], cal});
		noise = $urandom;
		write_reg(slpg_pkg::REG_DEPLOY_PERIOD, {noise[slpg_pkg::DATA_W-1:slpg_pkg::PER_W], dep});
		noise = $urandom;
		write_reg(slpg_pkg::REG_SLOT_LENGTH, {noise[slpg_pkg::DATA_W-1:slpg_pkg::SLOT_W], slot});
		noise = $urandom;
		write_reg(slpg_pkg::REG_BRIGHTNESS, {noise[slpg_pkg::DATA_W-1:slpg_pkg::BRIGHT_W], pct});
	endtask

	task automatic test_reset_defaults();
		for (int i = slpg_pkg::REG_FAILSAFE_PERIOD; i <= slpg_pkg::REG_BRIGHTNESS; i++) begin
			check_readback(i[2:0]);
		end
		send_beat(make_request(slpg_pkg::MODE_ARMED, 1'b1, '0));
		send_beat(make_request(slpg_pkg::MODE_ARMED, 1'b0, '1));
		send_beat(make_request(slpg_pkg::MODE_FAILSAFE, 1'b1, 32'd124));
		send_beat(make_request(slpg_pkg::MODE_FAILSAFE, 1'b1, 32'd125));
		send_beat(make_request(slpg_pkg::MODE_FAILSAFE, 1'b0, 32'd249));
		send_beat(make_request(slpg_pkg::MODE_FAILSAFE, 1'b0, 32'd250));
		send_beat(make_request(slpg_pkg::MODE_DISARMED, 1'b1, 32'd999));
		send_beat(make_request(slpg_pkg::MODE_DISARMED, 1'b1, 32'd1000));
		send_beat(make_request(slpg_pkg::MODE_DISARMED, 1'b0, '0));
		send_beat(make_request(slpg_pkg::MODE_DISARMED, 1'b0, 32'd150));
		send_beat(make_request(slpg_pkg::MODE_DISARMED, 1'b0, 32'd250));
		send_beat(make_request(slpg_pkg::MODE_DISARMED, 1'b0, 32'd399));
		send_beat(make_request(slpg_pkg::MODE_DISARMED, 1'b0, 32'd400));
		send_beat(make_request(slpg_pkg::MODE_DISARMED, 1'b0, 32'd1999));
		send_beat(make_request(slpg_pkg::MODE_ESC_CAL, 1'b1, 32'd99));
		send_beat(make_request(slpg_pkg::MODE_ESC_CAL, 1'b1, 32'd100));
		send_beat(make_request(slpg_pkg::MODE_ESC_CAL, 1'b0, 32'd299));
		send_beat(make_request(slpg_pkg::MODE_ESC_CAL, 1'b0, 32'd400));
		send_beat(make_request(slpg_pkg::MODE_DEPLOY, 1'b1, 32'd450));
		send_beat(make_request(slpg_pkg::MODE_DEPLOY, 1'b1, 32'd550));
		send_beat(make_request(slpg_pkg::MODE_DEPLOY, 1'b0, 32'd599));
		send_beat(make_request(slpg_pkg::MODE_DEPLOY, 1'b0, 32'd600));
		for (int m = slpg_pkg::MODE_DEPLOY + 1; m < 8; m++) begin
			send_beat(make_request(m[2:0], 1'b0, '1));
		end
		wait_results_drained();
	endtask

	task automatic test_register_extremes();
		apply_settings('0, '0, '0, '0, '0, 7'd101);
		send_traffic(20);
		apply_settings(16'd1, 16'd1, 16'd1, 16'd1, 12'd1, '0);
		send_traffic(20);
		apply_settings('1, '1, '1, '1, '1, '1);
		send_traffic(60);
	endtask

	task automatic test_unmapped_index();
		apply_settings(16'd40, 16'd300, 16'd120, 16'd200, 12'd10, 7'd55);
		write_reg(REG_SPARE_A, $urandom);
		write_reg(REG_SPARE_B, $urandom);
		repeat (3) @(posedge clk);
		send_traffic(30);
	endtask

	task automatic test_output_backpressure();
		wait_results_drained();
		long_stall_req = 1'b1;
		repeat (3 * PIPE_LATENCY + 10) send_beat(random_request());
		wait_results_drained();
	endtask

	task automatic test_random_settings();
		logic [slpg_pkg::SLOT_W-1:0]   slot;
		logic [slpg_pkg::BRIGHT_W-1:0] pct;
		for (int ph = 0; ph < 10; ph++) begin
			case ($urandom_range(0, 4))
			0:       slot = '0;
			1:       slot = slpg_pkg::SLOT_W'(1);
			2:       slot = '1;
			3:       slot = slpg_pkg::SLOT_W'($urandom_range(1, 40));
			default: slot = slpg_pkg::SLOT_W'($urandom);
			endcase
			case ($urandom_range(0, 3))
			0:       pct = '0;
			1:       pct = slpg_pkg::BRIGHT_W'(PERCENT);
			2:       pct = '1;
			default: pct = slpg_pkg::BRIGHT_W'($urandom_range(0, 127));
			endcase
			apply_settings(pick_period(), pick_period(), pick_period(), pick_period(), slot, pct);
			send_traffic(100);
		end
	endtask

	initial begin : rx_pacing
		int unsigned stall_left;
		int unsigned window_left;
		int unsigned ready_pct;
		stall_left  = 0;
		window_left = 0;
		ready_pct   = 100;
		forever begin
			@(posedge clk);
			if (long_stall_req) begin
				long_stall_req = 1'b0;
				stall_left = LONG_STALL;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				if (window_left == 0) begin
					window_left = $urandom_range(1, 64);
					case ($urandom_range(0, 3))
					0, 1:    ready_pct = 100;
					2:       ready_pct = 70;
					default: ready_pct = 25;
					endcase
				end
				window_left--;
				out_ready <= ($urandom_range(0, 99) < ready_pct);
			end
		end
	end

	always @(posedge clk) begin : result_check
		slpg_pkg::out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_leds.size() == 0) begin
				$error("output beat with no result expected");
				error_count++;
			end else begin
				want = expected_leds.pop_front();
				compare_field("led_on", slpg_pkg::CHAN_W'(want.led_on),
					slpg_pkg::CHAN_W'(out_data.led_on));
				compare_field("red", want.red, out_data.red);
				compare_field("green", want.green, out_data.green);
				compare_field("blue", want.blue, out_data.blue);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$error("no beat moved for %0d cycles", idle_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_ready = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		failsafe_per = slpg_pkg::RST_FAILSAFE_PERIOD;
		disarmed_per = slpg_pkg::RST_DISARMED_PERIOD;
		cal_per      = slpg_pkg::RST_CAL_PERIOD;
		deploy_per   = slpg_pkg::RST_DEPLOY_PERIOD;
		slot_len     = slpg_pkg::RST_SLOT_LENGTH;
		bright_pct   = slpg_pkg::RST_BRIGHTNESS;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_extremes();
		test_unmapped_index();
		test_output_backpressure();
		test_random_settings();
		wait_results_drained();
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
